// File: design/pdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_pkg
// Shared types, codes and sizes of the password door lock controller.
// ----------------------------------------------------------------------------
package pdl_pkg;

    localparam int PASSWORD_LEN = 5;
    localparam int IDX_W        = (PASSWORD_LEN > 1) ? $clog2(PASSWORD_LEN) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PASSWORD_LEN - 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_TICKS = 3'd4;

    // Item kinds
    localparam logic [1:0] OP_DIGIT  = 2'd0;
    localparam logic [1:0] OP_OPTION = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Option codes
    localparam logic [7:0] OPT_SET  = 8'd0;
    localparam logic [7:0] OPT_OPEN = 8'd1;

    // Reply codes
    localparam logic [1:0] REPLY_NONE     = 2'd0;
    localparam logic [1:0] REPLY_MATCH    = 2'd1;
    localparam logic [1:0] REPLY_MISMATCH = 2'd2;

    // Motor drive codes
    localparam logic [1:0] DRIVE_STOP = 2'd0;
    localparam logic [1:0] DRIVE_CW   = 2'd1;
    localparam logic [1:0] DRIVE_ACW  = 2'd2;

    // Reported mode codes
    localparam logic [2:0] CM_SET1    = 3'd0;
    localparam logic [2:0] CM_SET2    = 3'd1;
    localparam logic [2:0] CM_VERIFY  = 3'd2;
    localparam logic [2:0] CM_OPTION  = 3'd3;
    localparam logic [2:0] CM_LOCKOPT = 3'd4;
    localparam logic [2:0] CM_MOTOR   = 3'd5;
    localparam logic [2:0] CM_BUZZER  = 3'd6;

    localparam logic [2:0] ATTEMPT_MAX = 3'd7;
    localparam logic [7:0] TICK_MAX    = 8'hFF;

    typedef enum logic [6:0] {
        MODE_SET1    = 7'b0000001,
        MODE_SET2    = 7'b0000010,
        MODE_VERIFY  = 7'b0000100,
        MODE_OPTION  = 7'b0001000,
        MODE_LOCKOPT = 7'b0010000,
        MODE_MOTOR   = 7'b0100000,
        MODE_BUZZER  = 7'b1000000
    } mode_t;

    typedef enum logic [3:0] {
        PH_STOP  = 4'b0001,
        PH_CW    = 4'b0010,
        PH_PAUSE = 4'b0100,
        PH_ACW   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0] reply_code;
        logic [1:0] motor_drive;
        logic       buzzer_active;
        logic       awaiting_option;
        logic [2:0] control_mode;
    } result_t;

    typedef struct packed {
        logic [2:0] max_attempts;
        logic [7:0] lockout_ticks;
        logic [7:0] forward_ticks;
        logic [7:0] pause_ticks;
        logic [7:0] reverse_ticks;
    } cfg_t;

endpackage

// File: design/pdl_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_cfg_regs
// Configuration register file; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module pdl_cfg_regs import pdl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_attempts  <= 3'd3;
            cfg_reg.lockout_ticks <= 8'd20;
            cfg_reg.forward_ticks <= 8'd5;
            cfg_reg.pause_ticks   <= 8'd1;
            cfg_reg.reverse_ticks <= 8'd5;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_ATTEMPTS:  cfg_reg.max_attempts  <= cfg_wdata[2:0];
                CFG_LOCKOUT_TICKS: cfg_reg.lockout_ticks <= cfg_wdata;
                CFG_FORWARD_TICKS: cfg_reg.forward_ticks <= cfg_wdata;
                CFG_PAUSE_TICKS:   cfg_reg.pause_ticks   <= cfg_wdata;
                CFG_REVERSE_TICKS: cfg_reg.reverse_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/pdl_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_in_stage
// Input register: captures one item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module pdl_in_stage import pdl_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: design/pdl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_core
// Lock state machine: entry compare, attempts, motor and buzzer timing.
// ----------------------------------------------------------------------------
module pdl_core import pdl_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    mode_t            mode_reg, mode_next;
    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] digit_index_reg, digit_index_next;
    logic             matches_reg, matches_next;
    logic [2:0]       attempt_reg, attempt_next;
    logic [7:0]       tick_reg, tick_next;
    logic [7:0]       first_entry_reg [PASSWORD_LEN];
    logic [7:0]       stored_reg [PASSWORD_LEN];

    logic             first_we;
    logic             copy_en;
    logic [1:0]       reply;
    logic [7:0]       cmp_byte;
    logic             match_new;
    logic [2:0]       attempt_inc;
    logic [2:0]       attempt_limit;
    logic [7:0]       tick_inc;
    logic [7:0]       tick_limit;
    logic             tick_done;

    assign cmp_byte      = (mode_reg == MODE_SET2) ? first_entry_reg[digit_index_reg]
                                                   : stored_reg[digit_index_reg];
    assign match_new     = matches_reg && (cmp_byte == item.data_byte);
    assign attempt_inc   = (attempt_reg == ATTEMPT_MAX) ? ATTEMPT_MAX : attempt_reg + 3'd1;
    assign attempt_limit = (cfg.max_attempts == 3'd0) ? 3'd1 : cfg.max_attempts;
    assign tick_inc      = (tick_reg == TICK_MAX) ? TICK_MAX : tick_reg + 8'd1;
    assign tick_done     = tick_inc >= tick_limit;

    always_comb begin
        case (phase_reg)
            PH_CW:    tick_limit = cfg.forward_ticks;
            PH_PAUSE: tick_limit = cfg.pause_ticks;
            PH_ACW:   tick_limit = cfg.reverse_ticks;
            default:  tick_limit = cfg.lockout_ticks;
        endcase
        if (mode_reg == MODE_BUZZER) begin
            tick_limit = cfg.lockout_ticks;
        end
    end

    always_comb begin
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        digit_index_next = digit_index_reg;
        matches_next     = matches_reg;
        attempt_next     = attempt_reg;
        tick_next        = tick_reg;
        first_we         = 1'b0;
        copy_en          = 1'b0;
        reply            = REPLY_NONE;

        if (item.opcode == OP_DIGIT && mode_reg inside {MODE_SET1, MODE_SET2, MODE_VERIFY}) begin
            if (mode_reg == MODE_SET1) begin
                first_we = 1'b1;
            end else begin
                matches_next = match_new;
            end
            digit_index_next = (digit_index_reg == LAST_IDX) ? '0 : digit_index_reg + 1'b1;
            if (digit_index_reg == LAST_IDX) begin
                case (mode_reg)
                    MODE_SET1: begin
                        mode_next    = MODE_SET2;
                        matches_next = 1'b1;
                    end
                    MODE_SET2: begin
                        copy_en      = match_new;
                        reply        = match_new ? REPLY_MATCH : REPLY_MISMATCH;
                        mode_next    = MODE_VERIFY;
                        matches_next = 1'b1;
                        attempt_next = '0;
                        tick_next    = '0;
                        phase_next   = PH_STOP;
                    end
                    default: begin
                        if (match_new) begin
                            reply        = REPLY_MATCH;
                            attempt_next = '0;
                            mode_next    = MODE_OPTION;
                        end else begin
                            reply        = REPLY_MISMATCH;
                            attempt_next = attempt_inc;
                            if (attempt_inc >= attempt_limit) begin
                                mode_next = MODE_LOCKOPT;
                            end else begin
                                matches_next = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end else if (item.opcode == OP_OPTION && mode_reg == MODE_OPTION) begin
            if (item.data_byte == OPT_OPEN) begin
                mode_next  = MODE_MOTOR;
                phase_next = PH_CW;
                tick_next  = '0;
            end else if (item.data_byte == OPT_SET) begin
                mode_next        = MODE_SET1;
                digit_index_next = '0;
                matches_next     = 1'b1;
            end else begin
                mode_next        = MODE_VERIFY;
                digit_index_next = '0;
                matches_next     = 1'b1;
                attempt_next     = '0;
                tick_next        = '0;
                phase_next       = PH_STOP;
            end
        end else if (item.opcode == OP_OPTION && mode_reg == MODE_LOCKOPT) begin
            if (item.data_byte == OPT_OPEN) begin
                mode_next = MODE_BUZZER;
                tick_next = '0;
            end else begin
                mode_next        = MODE_VERIFY;
                digit_index_next = '0;
                matches_next     = 1'b1;
                attempt_next     = '0;
                tick_next        = '0;
                phase_next       = PH_STOP;
            end
        end else if (item.opcode == OP_TICK && mode_reg inside {MODE_MOTOR, MODE_BUZZER}) begin
            tick_next = tick_done ? 8'd0 : tick_inc;
            if (tick_done || (mode_reg == MODE_MOTOR && phase_reg == PH_STOP)) begin
                case (phase_reg)
                    PH_CW:    phase_next = (cfg.pause_ticks == 8'd0) ? PH_ACW : PH_PAUSE;
                    PH_PAUSE: phase_next = PH_ACW;
                    default: begin
                        // end of closing run, stray stop phase or end of lockout
                        mode_next        = MODE_VERIFY;
                        digit_index_next = '0;
                        matches_next     = 1'b1;
                        attempt_next     = '0;
                        tick_next        = '0;
                        phase_next       = PH_STOP;
                    end
                endcase
            end
        end
    end

    // Result shows the state after the item
    always_comb begin
        result.reply_code      = reply;
        result.motor_drive     = DRIVE_STOP;
        result.buzzer_active   = (mode_next == MODE_BUZZER);
        result.awaiting_option = (mode_next == MODE_OPTION) || (mode_next == MODE_LOCKOPT);
        if (mode_next == MODE_MOTOR && phase_next == PH_CW) begin
            result.motor_drive = DRIVE_CW;
        end else if (mode_next == MODE_MOTOR && phase_next == PH_ACW) begin
            result.motor_drive = DRIVE_ACW;
        end
        case (mode_next)
            MODE_SET1:    result.control_mode = CM_SET1;
            MODE_SET2:    result.control_mode = CM_SET2;
            MODE_VERIFY:  result.control_mode = CM_VERIFY;
            MODE_OPTION:  result.control_mode = CM_OPTION;
            MODE_LOCKOPT: result.control_mode = CM_LOCKOPT;
            MODE_MOTOR:   result.control_mode = CM_MOTOR;
            MODE_BUZZER:  result.control_mode = CM_BUZZER;
            default:      result.control_mode = CM_SET1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_SET1;
            phase_reg       <= PH_STOP;
            digit_index_reg <= '0;
            matches_reg     <= 1'b1;
            attempt_reg     <= '0;
            tick_reg        <= '0;
        end else if (fire) begin
            mode_reg        <= mode_next;
            phase_reg       <= phase_next;
            digit_index_reg <= digit_index_next;
            matches_reg     <= matches_next;
            attempt_reg     <= attempt_next;
            tick_reg        <= tick_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && first_we) begin
            first_entry_reg[digit_index_reg] <= item.data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PASSWORD_LEN; i++) begin
                stored_reg[i] <= '0;
            end
        end else if (fire && copy_en) begin
            for (int i = 0; i < PASSWORD_LEN; i++) begin
                stored_reg[i] <= first_entry_reg[i];
            end
        end
    end

    a_phase_idle_outside_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_MOTOR) |-> (phase_reg == PH_STOP))
        else $error("motor phase active outside motor mode");

    a_phase_running_in_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_MOTOR) |-> (phase_reg != PH_STOP))
        else $error("motor mode without a running phase");

    a_reply_only_on_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (reply != REPLY_NONE) |-> (item.opcode == OP_DIGIT && digit_index_reg == LAST_IDX))
        else $error("reply raised on an item that does not close an entry");

    a_set1_to_set2: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && mode_reg == MODE_SET1 && item.opcode == OP_DIGIT
            && digit_index_reg == LAST_IDX) |=> (mode_reg == MODE_SET2))
        else $error("first set entry did not move to second entry");

endmodule

// File: design/password_door_lock_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// password_door_lock_controller_unit
// Digital combination lock: password set/verify, attempt lockout with buzzer,
// and timed motor open/close sequence driven by tick items.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                         Moves
//   -------   ---------------------------   ---------------------------------
//   input     s_valid / s_ready / s_item    one item: opcode, data_byte
//   result    m_valid / m_ready / m_result  one result item per input item
//   config    cfg_we / cfg_index / cfg_wdata register write, no wait
//
// Every input item yields exactly one result item. An item is taken every
// cycle while the result is not stalled; it passes the input register, then
// the result register, with the single state update between them.
// Reset (aresetn low, synchronous) empties both registers, restores the
// register defaults, clears the stored password and returns to set mode.
// A stalled result holds the core; the input register still takes one more
// item while the result waits, and s_ready drops only when both are full.
// ----------------------------------------------------------------------------
module password_door_lock_controller_unit import pdl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  item_t                 s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    fire;
    result_t result;
    logic    out_valid_reg;
    result_t result_reg;

    // Advance when the result register is empty or being drained this cycle
    assign advance = !out_valid_reg || m_ready;
    // Consume the held item into the core and the result register
    assign fire    = item_valid && advance;

    pdl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdl_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pdl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    // Result register: hold while stalled, load on every consumed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = result_reg;

endmodule
